>>> rtl/core/afc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package afc_pkg;

    // matrix words are always 32-bit signed fixed point
    localparam int MAT_W      = 32;
    // plane component: exact sum of two matrix words
    localparam int PLANE_W    = MAT_W + 1;
    localparam int NUM_REGS   = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int NUM_PLANES = 6;
    localparam int NUM_AXES   = 3;
    localparam int NUM_COMP   = 4;
    localparam int NUM_COLS   = 4;
    localparam int NUM_STAGES = 4;

    // component slots of a plane or a column
    localparam int COMP_A = 0;
    localparam int COMP_B = 1;
    localparam int COMP_C = 2;
    localparam int COMP_D = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COL0_LO = 4'd0,
        REG_COL0_HI = 4'd1,
        REG_COL1_LO = 4'd2,
        REG_COL1_HI = 4'd3,
        REG_COL2_LO = 4'd4,
        REG_COL2_HI = 4'd5,
        REG_COL3_LO = 4'd6,
        REG_COL3_HI = 4'd7
    } cfg_reg_t;

    // plane codes, in test order
    typedef enum logic [2:0] {
        PLANE_NEAR   = 3'd0,
        PLANE_FAR    = 3'd1,
        PLANE_LEFT   = 3'd2,
        PLANE_RIGHT  = 3'd3,
        PLANE_TOP    = 3'd4,
        PLANE_BOTTOM = 3'd5
    } plane_id_t;

endpackage

`default_nettype wire

>>> rtl/core/aabb_frustum_cull.sv
`timescale 1ns / 1ps
`default_nettype none

// Frustum cull of one axis-aligned box per beat. The six planes (near, far,
// left, right, top, bottom) are formed from the columns of the view-projection
// matrix written through the cfg port; each plane is tested against the box
// corner furthest along its normal, and the first plane that puts that corner
// strictly behind it is reported with culled set. A box is accepted every
// cycle unless a stall from m_tready has filled the pipeline; m_tvalid is the
// valid of the last of the four pipeline stages, the first of which loads at
// the accepting edge: plane build and corner pick, the eighteen
// plane-by-coordinate multipliers, two pairwise adds, and the final add with
// first-plane select. Each stage holds its beat while the stage after it is
// full and cannot move on, so m_tready low stalls without loss and bubbles
// close up.
// Only the low COORD_BITS bits of each coordinate are used, sign-extended.
// Matrix writes are taken at any time but must only be made while no box is
// in flight.
module aabb_frustum_cull
    import afc_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    // box beat
    input  wire                  s_tvalid,
    output logic                 s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    // (32 bits each, lowest first)
    input  wire  [191:0]         s_tdata,
    // result beat
    output logic                 m_tvalid,
    input  wire                  m_tready,
    // culled [0], plane_hit [3:1], zero [7:4]
    output logic [7:0]           m_tdata,
    // matrix register writes
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire  [CFG_IDX_W-1:0] cfg_index,
    input  wire  [63:0]          cfg_data
);

    localparam int FIELD_W = 32;
    localparam int PROD_W  = PLANE_W + COORD_BITS;
    localparam int DSC_W   = PLANE_W + FRAC_BITS;
    localparam int SUM_W   = ((PROD_W > DSC_W) ? PROD_W : DSC_W) + 2;

    // matrix registers
    logic [63:0] matrix_reg [NUM_REGS];

    // pipeline valids and per-stage ready
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] v_next;
    logic [NUM_STAGES-1:0] rdy;

    // stage 1: planes and chosen corner
    logic signed [PLANE_W-1:0]    colw [NUM_COLS][NUM_COMP];
    logic signed [COORD_BITS-1:0] box_min [NUM_AXES];
    logic signed [COORD_BITS-1:0] box_max [NUM_AXES];
    logic signed [PLANE_W-1:0]    s1_plane_next  [NUM_PLANES][NUM_COMP];
    logic signed [COORD_BITS-1:0] s1_corner_next [NUM_PLANES][NUM_AXES];
    logic signed [PLANE_W-1:0]    s1_plane_reg   [NUM_PLANES][NUM_COMP];
    logic signed [COORD_BITS-1:0] s1_corner_reg  [NUM_PLANES][NUM_AXES];

    // stage 2: products and scaled offset
    logic signed [PROD_W-1:0] s2_prod_next [NUM_PLANES][NUM_AXES];
    logic signed [DSC_W-1:0]  s2_dsc_next  [NUM_PLANES];
    logic signed [PROD_W-1:0] s2_prod_reg  [NUM_PLANES][NUM_AXES];
    logic signed [DSC_W-1:0]  s2_dsc_reg   [NUM_PLANES];

    // stage 3: pairwise sums
    logic signed [SUM_W-1:0] s3_sa_next [NUM_PLANES];
    logic signed [SUM_W-1:0] s3_sb_next [NUM_PLANES];
    logic signed [SUM_W-1:0] s3_sa_reg  [NUM_PLANES];
    logic signed [SUM_W-1:0] s3_sb_reg  [NUM_PLANES];

    // stage 4: result
    logic signed [SUM_W-1:0] total [NUM_PLANES];
    logic [NUM_PLANES-1:0]   neg;
    logic                    culled_next;
    plane_id_t               hit_next;
    logic                    culled_reg;
    plane_id_t               hit_reg;

    // matrix register file, unknown indexes ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NUM_REGS; r++) begin
                matrix_reg[r] <= '0;
            end
        end else if (cfg_valid && (cfg_index <= REG_COL3_HI)) begin
            matrix_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // handshake: a stage loads when empty or when its successor moves
    always_comb begin
        rdy[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
        v_next[0] = rdy[0] ? s_tvalid : v_reg[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            v_next[k] = rdy[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    assign s_tready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    // stage 1: column words, plane build, corner pick
    always_comb begin
        for (int k = 0; k < NUM_COLS; k++) begin
            colw[k][COMP_A] = PLANE_W'($signed(matrix_reg[2*k][31:0]));
            colw[k][COMP_B] = PLANE_W'($signed(matrix_reg[2*k][63:32]));
            colw[k][COMP_C] = PLANE_W'($signed(matrix_reg[2*k+1][31:0]));
            colw[k][COMP_D] = PLANE_W'($signed(matrix_reg[2*k+1][63:32]));
        end
        for (int j = 0; j < NUM_AXES; j++) begin
            box_min[j] = $signed(s_tdata[FIELD_W*j +: COORD_BITS]);
            box_max[j] = $signed(s_tdata[FIELD_W*(j+NUM_AXES) +: COORD_BITS]);
        end
        for (int i = 0; i < NUM_COMP; i++) begin
            s1_plane_next[PLANE_NEAR][i]   = colw[2][i];
            s1_plane_next[PLANE_FAR][i]    = colw[3][i] - colw[2][i];
            s1_plane_next[PLANE_LEFT][i]   = colw[3][i] + colw[0][i];
            s1_plane_next[PLANE_RIGHT][i]  = colw[3][i] - colw[0][i];
            s1_plane_next[PLANE_TOP][i]    = colw[3][i] - colw[1][i];
            s1_plane_next[PLANE_BOTTOM][i] = colw[3][i] + colw[1][i];
        end
        for (int p = 0; p < NUM_PLANES; p++) begin
            for (int j = 0; j < NUM_AXES; j++) begin
                s1_corner_next[p][j] = (s1_plane_next[p][j] > 0) ? box_max[j] : box_min[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            s1_plane_reg  <= s1_plane_next;
            s1_corner_reg <= s1_corner_next;
        end
    end

    // stage 2: normal times corner, offset aligned to product scale
    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            for (int j = 0; j < NUM_AXES; j++) begin
                s2_prod_next[p][j] = PROD_W'(s1_plane_reg[p][j]) *
                                     PROD_W'(s1_corner_reg[p][j]);
            end
            s2_dsc_next[p] = DSC_W'(s1_plane_reg[p][COMP_D]) <<< FRAC_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            s2_prod_reg <= s2_prod_next;
            s2_dsc_reg  <= s2_dsc_next;
        end
    end

    // stage 3: two partial sums per plane
    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            s3_sa_next[p] = SUM_W'(s2_prod_reg[p][0]) + SUM_W'(s2_prod_reg[p][1]);
            s3_sb_next[p] = SUM_W'(s2_prod_reg[p][2]) + SUM_W'(s2_dsc_reg[p]);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            s3_sa_reg <= s3_sa_next;
            s3_sb_reg <= s3_sb_next;
        end
    end

    // stage 4: final sum sign, first rejecting plane wins
    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            total[p] = s3_sa_reg[p] + s3_sb_reg[p];
            neg[p]   = total[p][SUM_W-1];
        end
        culled_next = |neg;
        if (neg[PLANE_NEAR]) begin
            hit_next = PLANE_NEAR;
        end else if (neg[PLANE_FAR]) begin
            hit_next = PLANE_FAR;
        end else if (neg[PLANE_LEFT]) begin
            hit_next = PLANE_LEFT;
        end else if (neg[PLANE_RIGHT]) begin
            hit_next = PLANE_RIGHT;
        end else if (neg[PLANE_TOP]) begin
            hit_next = PLANE_TOP;
        end else if (neg[PLANE_BOTTOM]) begin
            hit_next = PLANE_BOTTOM;
        end else begin
            hit_next = PLANE_NEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            culled_reg <= culled_next;
            hit_reg    <= hit_next;
        end
    end

    assign m_tvalid = v_reg[NUM_STAGES-1];
    assign m_tdata  = {4'b0000, hit_reg, culled_reg};

    // checks
    a_not_culled_near: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !culled_reg |-> hit_reg == PLANE_NEAR)
        else $error("plane_hit nonzero on a kept box");

    a_hit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> hit_reg <= PLANE_BOTTOM)
        else $error("plane_hit out of range");

    a_empty_takes: assert property (@(posedge aclk) disable iff (!aresetn)
        !v_reg[0] |-> s_tready)
        else $error("empty first stage refuses a beat");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[1] && !rdy[1] |=> v_reg[1] && $stable(s2_dsc_reg[0]))
        else $error("stalled stage lost its beat");

endmodule

`default_nettype wire
